>>> rtl/qkts_pkg.sv
// Shared types, constants and the step direction table for the knob time and tuning setter.
`default_nettype none

package qkts_pkg;

  localparam int DETENT_STEPS_DEF = 4;
  localparam int STEP_W           = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEP = 2'd3;

  localparam logic [15:0] FREQ_MIN_RST    = 16'd8810;
  localparam logic [15:0] FREQ_MAX_RST    = 16'd10790;
  localparam logic [7:0]  FREQ_STEP_RST   = 8'd20;
  localparam logic [7:0]  VOLUME_STEP_RST = 8'd50;

  localparam logic [5:0]  ALARM_MINUTE_RST = 6'd1;
  localparam logic [4:0]  ALARM_HOUR_RST   = 5'd1;
  localparam logic [15:0] FREQ_RST         = 16'd10790;
  localparam logic [11:0] VOLUME_RST       = 12'd819;

  localparam logic [11:0] VOLUME_MAX   = 12'h0fff;
  localparam logic [11:0] VOLUME_FLOOR = 12'd51;
  localparam logic [11:0] VOLUME_LOW   = 12'd52;
  localparam logic [5:0]  MINUTES_HOUR = 6'd60;
  localparam logic [4:0]  HOURS_DAY    = 5'd24;
  localparam logic [4:0]  HOUR_LAST    = 5'd23;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  typedef struct packed {
    logic [1:0] left_phase;
    logic [1:0] right_phase;
    logic       clock_set;
    logic       alarm_set;
    logic       tune_set;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  clock_minute;
    logic [4:0]  clock_hour;
    logic [5:0]  alarm_minute;
    logic [4:0]  alarm_hour;
    logic [15:0] tuned_freq;
    logic [11:0] volume_out;
    logic        retune;
  } out_word_t;

  typedef struct packed {
    logic [15:0] freq_min;
    logic [15:0] freq_max;
    logic [7:0]  freq_step;
    logic [7:0]  volume_step;
  } cfg_regs_t;

  typedef struct packed {
    logic up;
    logic dn;
  } knob_det_t;

  function automatic logic [1:0] dir_lookup(input logic [3:0] idx);
    logic [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_CW;
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_CCW;
      default:                  d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qkts_knob.sv
// Per-knob phase tracking and step counter that yields one detent per full count.
`default_nettype none

module qkts_knob
  import qkts_pkg::*;
#(
  parameter int DETENT_STEPS = DETENT_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic [1:0] phase,
  output knob_det_t       det
);

  localparam logic signed [STEP_W-1:0] DET_POS = STEP_W'(DETENT_STEPS);
  localparam logic signed [STEP_W-1:0] DET_NEG = -DET_POS;

  logic [1:0]               prev_r;
  logic signed [STEP_W-1:0] steps_r;
  logic signed [STEP_W-1:0] steps_inc;
  logic signed [STEP_W-1:0] steps_nxt;
  logic [1:0]               dir;

  always_comb begin
    dir = dir_lookup({prev_r, phase});
    case (dir)
      DIR_CW:  steps_inc = steps_r + STEP_W'(1);
      DIR_CCW: steps_inc = steps_r - STEP_W'(1);
      default: steps_inc = steps_r;
    endcase
    det.up    = (steps_inc >= DET_POS);
    det.dn    = (steps_inc <= DET_NEG);
    steps_nxt = (det.up || det.dn) ? '0 : steps_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      steps_r <= '0;
    end else if (advance) begin
      prev_r  <= phase;
      steps_r <= steps_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qkts_core.sv
// Setpoint state: clock, alarm, tuned frequency and volume, updated by knob detents.
`default_nettype none

module qkts_core
  import qkts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      advance,
  input  wire in_word_t  word,
  input  wire knob_det_t ldet,
  input  wire knob_det_t rdet,
  input  wire cfg_regs_t cfg,
  output out_word_t      result
);

  logic [5:0]  clk_min_r, clk_min_nxt;
  logic [4:0]  clk_hr_r, clk_hr_nxt;
  logic [5:0]  alm_min_r, alm_min_nxt;
  logic [4:0]  alm_hr_r, alm_hr_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic [11:0] vol_r, vol_nxt;

  logic sel_clock, sel_alarm, sel_freq, sel_vol;
  logic signed [1:0]  ld, rd;
  logic signed [2:0]  dsum;
  logic [5:0]  min_base, min_wrap;
  logic [4:0]  hr_base, hr_wrap;
  logic signed [6:0]  min_sum;
  logic signed [5:0]  hr_sum;
  logic        f_up, f_dn, moved;
  logic signed [17:0] f_raw, f_lo, fmin_s, fmax_s;
  logic [15:0] f_fin;
  logic signed [13:0] delta, v_sum;
  logic [11:0] v_fin;

  always_comb begin
    sel_clock = word.clock_set;
    sel_alarm = !word.clock_set && word.alarm_set;
    sel_freq  = !word.clock_set && !word.alarm_set && word.tune_set;
    sel_vol   = !word.clock_set && !word.alarm_set && !word.tune_set;

    ld   = ldet.up ? 2'sd1 : (ldet.dn ? -2'sd1 : 2'sd0);
    rd   = rdet.up ? 2'sd1 : (rdet.dn ? -2'sd1 : 2'sd0);
    dsum = 3'(ld) + 3'(rd);

    min_base = sel_clock ? clk_min_r : alm_min_r;
    hr_base  = sel_clock ? clk_hr_r : alm_hr_r;
    min_sum  = $signed({1'b0, min_base}) + 7'(ld);
    hr_sum   = $signed({1'b0, hr_base}) + 6'(rd);
    if (min_sum >= $signed({1'b0, MINUTES_HOUR})) begin
      min_wrap = 6'(min_sum - $signed({1'b0, MINUTES_HOUR}));
    end else if (min_sum < 0) begin
      min_wrap = 6'(min_sum + $signed({1'b0, MINUTES_HOUR}));
    end else begin
      min_wrap = min_sum[5:0];
    end
    if (hr_sum >= $signed({1'b0, HOURS_DAY})) begin
      hr_wrap = '0;
    end else if (hr_sum < 0) begin
      hr_wrap = HOUR_LAST;
    end else begin
      hr_wrap = hr_sum[4:0];
    end

    f_up   = ldet.up || rdet.up;
    f_dn   = !f_up && (ldet.dn || rdet.dn);
    moved  = f_up || f_dn;
    fmin_s = $signed({2'b00, cfg.freq_min});
    fmax_s = $signed({2'b00, cfg.freq_max});
    if (f_up) begin
      f_raw = $signed({2'b00, freq_r}) + $signed({10'd0, cfg.freq_step});
    end else begin
      f_raw = $signed({2'b00, freq_r}) - $signed({10'd0, cfg.freq_step});
    end
    f_lo  = (f_raw < fmin_s) ? fmax_s : f_raw;
    f_fin = (f_lo > fmax_s) ? cfg.freq_min : f_lo[15:0];

    case (dsum)
      3'sd2:   delta = $signed({5'd0, cfg.volume_step, 1'b0});
      3'sd1:   delta = $signed({6'd0, cfg.volume_step});
      -3'sd1:  delta = -$signed({6'd0, cfg.volume_step});
      -3'sd2:  delta = -$signed({5'd0, cfg.volume_step, 1'b0});
      default: delta = '0;
    endcase
    v_sum = $signed({2'b00, vol_r}) + delta;
    if (v_sum > $signed({2'b00, VOLUME_MAX})) begin
      v_fin = VOLUME_MAX;
    end else if (v_sum < $signed({2'b00, VOLUME_FLOOR})) begin
      v_fin = VOLUME_LOW;
    end else begin
      v_fin = v_sum[11:0];
    end

    clk_min_nxt = sel_clock ? min_wrap : clk_min_r;
    clk_hr_nxt  = sel_clock ? hr_wrap : clk_hr_r;
    alm_min_nxt = sel_alarm ? min_wrap : alm_min_r;
    alm_hr_nxt  = sel_alarm ? hr_wrap : alm_hr_r;
    freq_nxt    = (sel_freq && moved) ? f_fin : freq_r;
    vol_nxt     = sel_vol ? v_fin : vol_r;

    result.clock_minute = clk_min_nxt;
    result.clock_hour   = clk_hr_nxt;
    result.alarm_minute = alm_min_nxt;
    result.alarm_hour   = alm_hr_nxt;
    result.tuned_freq   = freq_nxt;
    result.volume_out   = vol_nxt;
    result.retune       = sel_freq && moved;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_min_r <= '0;
      clk_hr_r  <= '0;
      alm_min_r <= ALARM_MINUTE_RST;
      alm_hr_r  <= ALARM_HOUR_RST;
      freq_r    <= FREQ_RST;
      vol_r     <= VOLUME_RST;
    end else if (advance) begin
      clk_min_r <= clk_min_nxt;
      clk_hr_r  <= clk_hr_nxt;
      alm_min_r <= alm_min_nxt;
      alm_hr_r  <= alm_hr_nxt;
      freq_r    <= freq_nxt;
      vol_r     <= vol_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/quadrature_knob_time_tuning_setter.sv
// Top level: input and result registers, configuration registers and the knob decoders.
//
// Takes one knob sample word per clock while in_stall is low and gives one result word per
// sample; it waits in the input register until out_stall is low or no result is pending.
// Each sample passes an input register, one pass of short logic (direction table, step
// counters, wraps and clamps) and a result register; the two registers together let a
// new word enter while a finished result waits. Configuration registers reset to defaults.
// The user must write them via cfg_we, cfg_index, cfg_wdata only while idle; not enforced.
`default_nettype none

module quadrature_knob_time_tuning_setter
  import qkts_pkg::*;
#(
  parameter int DETENT_STEPS = DETENT_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  logic      s1_adv, in_acc;
  cfg_regs_t cfg_r;
  knob_det_t ldet, rdet;
  out_word_t result;

  always_comb begin
    s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall      = s1_valid_r && !s1_adv;
    in_acc        = in_valid && !in_stall;
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_word;
    end
    if (s1_adv) begin
      out_word_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_min    <= FREQ_MIN_RST;
      cfg_r.freq_max    <= FREQ_MAX_RST;
      cfg_r.freq_step   <= FREQ_STEP_RST;
      cfg_r.volume_step <= VOLUME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_MIN:    cfg_r.freq_min    <= cfg_wdata;
        REG_FREQ_MAX:    cfg_r.freq_max    <= cfg_wdata;
        REG_FREQ_STEP:   cfg_r.freq_step   <= cfg_wdata[7:0];
        REG_VOLUME_STEP: cfg_r.volume_step <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  qkts_knob #(.DETENT_STEPS(DETENT_STEPS)) u_knob_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .phase   (s1_word_r.left_phase),
    .det     (ldet)
  );

  qkts_knob #(.DETENT_STEPS(DETENT_STEPS)) u_knob_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .phase   (s1_word_r.right_phase),
    .det     (rdet)
  );

  qkts_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .word    (s1_word_r),
    .ldet    (ldet),
    .rdet    (rdet),
    .cfg     (cfg_r),
    .result  (result)
  );

  a_minutes_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.clock_minute < MINUTES_HOUR) &&
                    (out_word_r.alarm_minute < MINUTES_HOUR))
    else $error("minute out of range");

  a_hours_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.clock_hour < HOURS_DAY) &&
                    (out_word_r.alarm_hour < HOURS_DAY))
    else $error("hour out of range");

  a_volume_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.volume_out >= VOLUME_FLOOR))
    else $error("volume below floor");

  a_retune_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_word_r.clock_set || s1_word_r.alarm_set ||
               !s1_word_r.tune_set) |=> !out_word_r.retune)
    else $error("retune outside tuning mode");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word not presented");

endmodule

`default_nettype wire
